// File: rtl/core/cbs_pkg.sv
// Package for the centered binomial sampler: payload structs, the result group
// type and the configuration register indexes. No dependencies.

package cbs_pkg;

  // Fixed field widths.
  localparam int unsigned ByteW        = 8;
  localparam int unsigned SampleW      = 5;
  localparam int unsigned EtaW         = 4;
  localparam int unsigned CountW       = 11;
  localparam int unsigned CfgDataW     = 11;
  localparam int unsigned PairsPerByte = 4;
  localparam int unsigned GroupIdxW    = 2;

  // Register reset values.
  localparam logic [EtaW-1:0]   EtaReset   = EtaW'(2);
  localparam logic [CountW-1:0] CountReset = CountW'(128);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgEta         = 1'b0,
    CfgSampleCount = 1'b1
  } cbs_cfg_e;

  // One input item.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             start_req;
  } cbs_in_t;

  // One result item.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } cbs_out_t;

  // All results that one byte produces, with the index of the last valid one.
  typedef struct packed {
    logic [GroupIdxW-1:0]             last_idx;
    cbs_out_t [PairsPerByte-1:0]      res;
  } cbs_group_t;

endpackage

// File: rtl/core/cbs_pair_unit.sv
// Combinational pair accumulator: folds the four bit pairs of one byte into the
// running sample state and collects the finished samples. Depends on cbs_pkg.

module cbs_pair_unit import cbs_pkg::*; #(
  parameter int unsigned PairW = 3,
  parameter int unsigned CntW  = 11
) (
  input  cbs_in_t                   in_i,
  input  logic signed [SampleW-1:0] sum_i,
  input  logic [PairW-1:0]          pairs_i,
  input  logic [CntW-1:0]           done_i,
  input  logic [PairW:0]            eta_eff_i,
  input  logic [CntW-1:0]           n_eff_i,
  output logic signed [SampleW-1:0] sum_o,
  output logic [PairW-1:0]          pairs_o,
  output logic [CntW-1:0]           done_o,
  output logic                      has_res_o,
  output cbs_group_t                grp_o
);

  logic signed [SampleW-1:0] sum;
  logic [PairW-1:0]          pairs;
  logic [PairW:0]            pairs_nx;
  logic [CntW-1:0]           done;
  logic [GroupIdxW:0]        num;

  // Walk the pairs least significant first; a start request clears the state
  // before the first pair of this byte.
  always_comb begin
    sum      = in_i.start_req ? '0 : sum_i;
    pairs    = in_i.start_req ? '0 : pairs_i;
    done     = in_i.start_req ? '0 : done_i;
    pairs_nx = '0;
    num      = '0;
    grp_o    = '0;
    for (int p = 0; p < PairsPerByte; p++) begin
      if (done < n_eff_i) begin
        sum      = sum + SampleW'(in_i.data_byte[2*p]) - SampleW'(in_i.data_byte[2*p+1]);
        pairs_nx = {1'b0, pairs} + 1'b1;
        if (pairs_nx >= eta_eff_i) begin
          done = done + 1'b1;
          grp_o.res[num[GroupIdxW-1:0]].sample = sum;
          grp_o.res[num[GroupIdxW-1:0]].last   = (done == n_eff_i);
          num   = num + 1'b1;
          sum   = '0;
          pairs = '0;
        end else begin
          pairs = pairs_nx[PairW-1:0];
        end
      end
    end
    grp_o.last_idx = GroupIdxW'(num - 1'b1);
  end

  assign sum_o     = sum;
  assign pairs_o   = pairs;
  assign done_o    = done;
  assign has_res_o = (num != '0);

endmodule

// File: rtl/core/cbs_group_fifo.sv
// Two-entry queue of result groups with a serializer that hands out one
// sample per transfer. Depends on cbs_pkg.

module cbs_group_fifo import cbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cbs_group_t grp_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cbs_out_t   out_data_o
);

  localparam int unsigned Depth = 2;

  cbs_group_t           grp_q [Depth];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q;
  logic [GroupIdxW-1:0] sub_q;
  cbs_group_t           head;
  logic                 pop;

  // The head group and the sample within it that is offered next.
  assign head        = grp_q[rd_ptr_q];
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = head.res[sub_q];
  assign full_o      = (cnt_q == 2'(Depth));
  assign pop         = out_valid_o && out_ready_i && (sub_q == head.last_idx);

  // Group storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      grp_q[wr_ptr_q] <= grp_i;
    end
  end

  // Pointers, occupancy and the sample index inside the head group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        sub_q    <= '0;
      end else if (out_valid_o && out_ready_i) begin
        sub_q <= sub_q + 1'b1;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/centered_binomial_sampler.sv
// Top level of the centered binomial sampler: input register, configuration
// registers, run state, pair unit and result queue. Depends on cbs_pkg,
// cbs_pair_unit and cbs_group_fifo.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | cbs_in_t  (byte, start)
//   out     | output    | out_valid_o/out_ready_i | cbs_out_t (sample, last)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte is taken into the input register; once the result queue has room,
// it is folded into the run state and its samples go into the queue. The
// single output port hands out one sample per cycle while out_ready_i is
// high; a byte yields at most one sample for eta of four or more, up to four
// for eta of one. The queue holds two bytes' worth of samples; an output stall
// fills it, and in_ready_o drops if a byte also waits in the input register.
// Reset restores eta 2 and 128 samples, starts a fresh run; no clearing pass.

module centered_binomial_sampler import cbs_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned MAX_ETA     = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cbs_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbs_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // The sample counter never needs to exceed what the count register can hold.
  localparam int unsigned CountRegMax = (1 << CountW) - 1;
  localparam int unsigned CntMax = (MAX_SAMPLES < CountRegMax) ? MAX_SAMPLES : CountRegMax;
  localparam int unsigned CntW   = $clog2(CntMax + 1);
  localparam int unsigned PairW  = (MAX_ETA > 1) ? $clog2(MAX_ETA) : 1;

  logic [EtaW-1:0]           eta_q;
  logic [CountW-1:0]         count_q;
  logic                      in_valid_q;
  cbs_in_t                   in_data_q;
  logic signed [SampleW-1:0] sum_q, sum_d;
  logic [PairW-1:0]          pairs_q, pairs_d;
  logic [CntW-1:0]           done_q, done_d;
  logic [PairW:0]            eta_eff;
  logic [CntW-1:0]           n_eff;
  logic                      fifo_full;
  logic                      fire;
  logic                      has_res;
  cbs_group_t                grp;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q   <= EtaReset;
      count_q <= CountReset;
    end else if (cfg_valid_i) begin
      case (cbs_cfg_e'(cfg_index_i))
        CfgEta:         eta_q   <= cfg_data_i[EtaW-1:0];
        CfgSampleCount: count_q <= cfg_data_i[CountW-1:0];
        default:        ;
      endcase
    end
  end

  // Effective eta and sample count: zero counts as one, large values saturate.
  always_comb begin
    if (eta_q == '0) begin
      eta_eff = (PairW + 1)'(1);
    end else if (int'(eta_q) > MAX_ETA) begin
      eta_eff = (PairW + 1)'(MAX_ETA);
    end else begin
      eta_eff = (PairW + 1)'(eta_q);
    end
    if (count_q == '0) begin
      n_eff = CntW'(1);
    end else if (int'(count_q) > MAX_SAMPLES) begin
      n_eff = CntW'(MAX_SAMPLES);
    end else begin
      n_eff = CntW'(count_q);
    end
  end

  // Input register; the held byte is processed once the queue has room.
  assign fire       = in_valid_q && !fifo_full;
  assign in_ready_o = !in_valid_q || !fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  cbs_pair_unit #(
    .PairW (PairW),
    .CntW  (CntW)
  ) u_pair_unit (
    .in_i      (in_data_q),
    .sum_i     (sum_q),
    .pairs_i   (pairs_q),
    .done_i    (done_q),
    .eta_eff_i (eta_eff),
    .n_eff_i   (n_eff),
    .sum_o     (sum_d),
    .pairs_o   (pairs_d),
    .done_o    (done_d),
    .has_res_o (has_res),
    .grp_o     (grp)
  );

  // Run state advances with every processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      pairs_q <= '0;
      done_q  <= '0;
    end else if (fire) begin
      sum_q   <= sum_d;
      pairs_q <= pairs_d;
      done_q  <= done_d;
    end
  end

  cbs_group_fifo u_group_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && has_res),
    .grp_i       (grp),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/cbs_checker.sv
// Port-level checks for the centered binomial sampler, attached by the bind
// statement at the end of this file. Depends on cbs_pkg.

module cbs_checker import cbs_pkg::*; #(
  parameter int unsigned MAX_ETA = 8
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input cbs_out_t out_data_o
);

  // An offered result holds until its transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Input back-pressure only happens while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A sample never leaves the range set by the largest eta.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_ETA > 15) ||
      ((int'(out_data_o.sample) >= -int'(MAX_ETA)) &&
       (int'(out_data_o.sample) <= int'(MAX_ETA))))
    else $error("sample outside the eta range");

endmodule

bind centered_binomial_sampler cbs_checker #(
  .MAX_ETA (MAX_ETA)
) u_cbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
